@@ hw/rtl/ppl_pkg.sv @@
// Package with shared constants, types and register codes of the printer line buffer.
`default_nettype none
package ppl_pkg;

    localparam int STORE_DEPTH = 32;
    localparam int CUR_W       = $clog2(STORE_DEPTH + 1);
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int FILL_W      = 6;
    localparam int PADDR_W     = 4;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    localparam logic [FILL_W-1:0] FILL_MAX = '1;

    localparam logic [1:0] REG_LINE_LIMIT    = 2'd0;
    localparam logic [1:0] REG_BUSY_TICKS    = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

    localparam logic [5:0]  LINE_LIMIT_RST = 6'd32;
    localparam logic [7:0]  BUSY_TICKS_RST = 8'd4;
    localparam logic [31:0] TIMEOUT_RST    = 32'd1000;

    localparam int CTL_STROBE   = 0;
    localparam int CTL_AUTOFEED = 1;
    localparam int CTL_INIT     = 2;
    localparam int CTL_SELECT   = 3;

    localparam int ST_NOT_BUSY = 7;
    localparam int ST_ACK      = 6;
    localparam int ST_SELECTED = 4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STATUS,
        S_BYTE
    } t_state;

    typedef struct packed {
        logic accept;
        logic advance;
        logic byte_phase;
    } t_cmd;

    typedef struct packed {
        logic no_bytes;
        logic last_byte;
    } t_sts;

    typedef struct packed {
        logic [5:0]  line_limit;
        logic [7:0]  busy_ticks;
        logic [31:0] timeout_ticks;
    } t_cfg;

endpackage
`default_nettype wire

@@ hw/rtl/ppl_if.sv @@
// Stream interfaces for poll ticks and result beats.
`default_nettype none
interface ppl_tick_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [7:0] control_byte;

    modport source (output valid, output data_byte, output control_byte, input ready);
    modport sink (input valid, input data_byte, input control_byte, output ready);
endinterface

interface ppl_result_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] status_byte;
    logic [7:0] line_byte;
    logic       last;

    modport source (output valid, output kind, output status_byte, output line_byte,
                    output last, input ready);
    modport sink (input valid, input kind, input status_byte, input line_byte,
                  input last, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/ppl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ppl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

@@ hw/rtl/ppl_ctrl.sv @@
// Controller that sequences tick acceptance, the status beat and the flushed bytes.
`default_nettype none
module ppl_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire ppl_pkg::t_sts i_sts,
    output ppl_pkg::t_cmd      o_cmd
);
    import ppl_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_STATUS;
                end
            end
            S_STATUS: begin
                if (i_out_ready) begin
                    n_state = i_sts.no_bytes ? S_IDLE : S_BYTE;
                end
            end
            S_BYTE: begin
                if (i_out_ready && i_sts.last_byte) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready       = 1'b0;
        o_out_valid      = 1'b0;
        o_cmd.accept     = 1'b0;
        o_cmd.advance    = 1'b0;
        o_cmd.byte_phase = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_STATUS: begin
                o_out_valid = 1'b1;
            end
            S_BYTE: begin
                o_out_valid      = 1'b1;
                o_cmd.byte_phase = 1'b1;
                o_cmd.advance    = i_out_ready;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ hw/rtl/ppl_datapath.sv @@
// Datapath with printer state, line store and result formatting.
`default_nettype none
module ppl_datapath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire ppl_pkg::t_cfg i_cfg,
    input  wire ppl_pkg::t_cmd i_cmd,
    output ppl_pkg::t_sts      o_sts,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic [7:0]    i_control_byte,
    output logic               o_kind,
    output logic [7:0]         o_status_byte,
    output logic [7:0]         o_line_byte,
    output logic               o_last
);
    import ppl_pkg::*;

    localparam logic [CUR_W-1:0]  CUR_CAP   = CUR_W'(STORE_DEPTH);
    localparam logic [FILL_W-1:0] LIMIT_CAP = FILL_W'(STORE_DEPTH);

    logic [CUR_W-1:0]  r_cursor;
    logic [FILL_W-1:0] r_fill;
    logic              r_wait_rel;
    logic [7:0]        r_busy;
    logic              r_timer_on;
    logic [31:0]       r_elapsed;
    logic              r_last_lf;
    logic [CUR_W-1:0]  r_count;
    logic [CUR_W-1:0]  r_idx;
    logic [7:0]        r_status;

    logic [CUR_W-1:0]  n_cursor;
    logic [FILL_W-1:0] n_fill;
    logic              n_wait_rel;
    logic [7:0]        n_busy;
    logic              n_timer_on;
    logic [31:0]       n_elapsed;
    logic              n_last_lf;
    logic [CUR_W-1:0]  n_count;
    logic [7:0]        n_status;

    logic              wr_en;
    logic [7:0]        wr_char;
    logic [CUR_W-1:0]  rd_idx;
    logic [7:0]        rd_data;

    always_comb begin
        logic              not_busy;
        logic [7:0]        ch;
        logic [FILL_W-1:0] limit;
        logic              eol_flush;
        logic              flush;

        not_busy   = !r_wait_rel && (r_busy == 8'd0);
        n_cursor   = r_cursor;
        n_fill     = r_fill;
        n_wait_rel = r_wait_rel;
        n_busy     = r_busy;
        n_timer_on = r_timer_on;
        n_elapsed  = (r_timer_on && (r_elapsed != '1)) ? r_elapsed + 32'd1 : r_elapsed;
        n_last_lf  = r_last_lf;
        n_status   = 8'd0;
        wr_en      = 1'b0;
        ch         = (i_data_byte == CH_CR) ? CH_LF : i_data_byte;
        wr_char    = ch;

        n_status[ST_NOT_BUSY] = not_busy;
        if (i_control_byte[CTL_SELECT]) begin
            n_status[ST_SELECTED] = 1'b1;
            if (!i_control_byte[CTL_INIT]) begin
                n_cursor   = '0;
                n_fill     = '0;
                n_timer_on = 1'b0;
                n_elapsed  = '0;
                n_wait_rel = 1'b0;
                n_busy     = '0;
                n_last_lf  = 1'b0;
            end else if (i_control_byte[CTL_STROBE]) begin
                if (not_busy) begin
                    if ((i_data_byte == CH_CR) && !i_control_byte[CTL_AUTOFEED]) begin
                        n_cursor = '0;
                    end else if (r_cursor < CUR_CAP) begin
                        wr_en     = 1'b1;
                        n_cursor  = r_cursor + CUR_W'(1);
                        n_last_lf = (ch == CH_LF);
                    end
                    if (r_fill != FILL_MAX) begin
                        n_fill = r_fill + FILL_W'(1);
                    end
                    n_wait_rel       = 1'b1;
                    n_timer_on       = 1'b1;
                    n_elapsed        = '0;
                    n_status[ST_ACK] = 1'b1;
                end
            end else begin
                if (r_wait_rel) begin
                    n_wait_rel = 1'b0;
                    n_busy     = i_cfg.busy_ticks;
                end else if (r_busy != 8'd0) begin
                    n_busy = r_busy - 8'd1;
                end
            end
        end

        limit     = (i_cfg.line_limit < LIMIT_CAP) ? i_cfg.line_limit : LIMIT_CAP;
        eol_flush = (n_fill >= limit) ||
                    ((n_fill != '0) && (n_cursor != '0) && n_last_lf);
        flush     = eol_flush || (n_timer_on && (n_elapsed >= i_cfg.timeout_ticks));
        n_count   = flush ? n_cursor : '0;
        if (flush) begin
            n_timer_on = 1'b0;
            n_elapsed  = '0;
            n_cursor   = '0;
            if (eol_flush) begin
                n_fill = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor   <= '0;
            r_fill     <= '0;
            r_wait_rel <= 1'b0;
            r_busy     <= '0;
            r_timer_on <= 1'b0;
            r_elapsed  <= '0;
            r_last_lf  <= 1'b0;
            r_count    <= '0;
            r_idx      <= '0;
        end else if (i_cmd.accept) begin
            r_cursor   <= n_cursor;
            r_fill     <= n_fill;
            r_wait_rel <= n_wait_rel;
            r_busy     <= n_busy;
            r_timer_on <= n_timer_on;
            r_elapsed  <= n_elapsed;
            r_last_lf  <= n_last_lf;
            r_count    <= n_count;
            r_idx      <= '0;
        end else if (i_cmd.advance) begin
            r_idx <= r_idx + CUR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_status <= n_status;
        end
    end

    assign rd_idx = i_cmd.advance ? r_idx + CUR_W'(1) : r_idx;

    ppl_ram #(
        .WIDTH(8),
        .DEPTH(STORE_DEPTH)
    ) u_line_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.accept && wr_en),
        .i_waddr(r_cursor[ADDR_W-1:0]),
        .i_wdata(wr_char),
        .i_raddr(rd_idx[ADDR_W-1:0]),
        .o_rdata(rd_data)
    );

    assign o_sts.no_bytes  = (r_count == '0);
    assign o_sts.last_byte = ((r_idx + CUR_W'(1)) == r_count);

    assign o_kind        = i_cmd.byte_phase;
    assign o_status_byte = i_cmd.byte_phase ? 8'd0 : r_status;
    assign o_line_byte   = i_cmd.byte_phase ? rd_data : 8'd0;
    assign o_last        = i_cmd.byte_phase ? o_sts.last_byte : o_sts.no_bytes;

endmodule
`default_nettype wire

@@ hw/rtl/parallel_printer_line_buffer.sv @@
// Top level of the parallel printer line buffer with its register port.
// The status beat is offered in the cycle after a tick is accepted.
// Flushed line bytes follow the status beat at one beat per cycle from the line RAM while the result sink is ready.
// A new tick is accepted only after the status beat and the n flushed bytes (0 to 32) of the last tick are taken.
// Reset: printer state clears and registers return to defaults; no clearing pass is run.
`default_nettype none
module parallel_printer_line_buffer (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    ppl_tick_if.sink                          i_tick,
    ppl_result_if.source                      o_res,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ppl_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready
);
    import ppl_pkg::*;

    t_cfg       r_cfg;
    t_cmd       cmd;
    t_sts       sts;
    logic [1:0] reg_idx;
    logic       wr_fire;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_fire = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_limit    <= LINE_LIMIT_RST;
            r_cfg.busy_ticks    <= BUSY_TICKS_RST;
            r_cfg.timeout_ticks <= TIMEOUT_RST;
        end else if (wr_fire) begin
            unique case (reg_idx)
                REG_LINE_LIMIT:    r_cfg.line_limit    <= pwdata[5:0];
                REG_BUSY_TICKS:    r_cfg.busy_ticks    <= pwdata[7:0];
                REG_TIMEOUT_TICKS: r_cfg.timeout_ticks <= pwdata;
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_LINE_LIMIT:    prdata = {26'd0, r_cfg.line_limit};
            REG_BUSY_TICKS:    prdata = {24'd0, r_cfg.busy_ticks};
            REG_TIMEOUT_TICKS: prdata = r_cfg.timeout_ticks;
            default:           prdata = 32'd0;
        endcase
    end

    ppl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_tick.valid),
        .o_in_ready (i_tick.ready),
        .o_out_valid(o_res.valid),
        .i_out_ready(o_res.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ppl_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_data_byte   (i_tick.data_byte),
        .i_control_byte(i_tick.control_byte),
        .o_kind        (o_res.kind),
        .o_status_byte (o_res.status_byte),
        .o_line_byte   (o_res.line_byte),
        .o_last        (o_res.last)
    );

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the printer line buffer: directed and random poll ticks checked against a line model.
module testbench;
    import ppl_pkg::*;

    typedef struct packed {
        logic       kind;
        logic [7:0] status_byte;
        logic [7:0] line_byte;
        logic       last;
    } t_beat;

    typedef struct {
        logic [7:0] data_byte;
        logic [7:0] control_byte;
        bit         wait_drained;
    } t_tick;

    logic               clk     = 1'b0;
    logic               rst_n   = 1'b0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [31:0]        pwdata  = '0;
    logic [31:0]        prdata;
    logic               pready;

    ppl_tick_if   tick_if ();
    ppl_result_if res_if ();

    parallel_printer_line_buffer dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_tick  (tick_if.sink),
        .o_res   (res_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 clk = ~clk;

    t_tick ticks_to_send[$];
    t_beat due_beats[$];
    int    mismatches  = 0;
    int    ticks_taken = 0;
    int    queued      = 0;
    int    cycle_no    = 0;
    int    hold_left   = 0;
    bit    hold_done   = 1'b0;
    int    gen_busy    = int'(BUSY_TICKS_RST);
    logic  calm;

    // Printer state as the line model sees it.
    logic [7:0]  line_mem [STORE_DEPTH] = '{default: 8'h00};
    int          col         = 0;
    int          fill        = 0;
    int          busy_left   = 0;
    bit          strobe_wait = 1'b0;
    bit          tmr_on      = 1'b0;
    logic [31:0] elapsed     = '0;
    logic [5:0]  cfg_limit   = LINE_LIMIT_RST;
    logic [7:0]  cfg_busy    = BUSY_TICKS_RST;
    logic [31:0] cfg_timeout = TIMEOUT_RST;

    assign calm = cycle_no >= 900 && cycle_no < 1300;

    function automatic void printer_tick(input logic [7:0] d, input logic [7:0] c);
        logic [7:0] st;
        logic [7:0] ch;
        bit         idle_now;
        bit         do_store;
        bit         flush;
        bit         eol;
        int         lim;
        int         n;
        st       = '0;
        do_store = 1'b0;
        ch       = d;
        if (tmr_on && elapsed != 32'hFFFF_FFFF) begin
            elapsed++;
        end
        idle_now = !strobe_wait && busy_left == 0;
        st[ST_NOT_BUSY] = idle_now;
        if (c[CTL_SELECT]) begin
            st[ST_SELECTED] = 1'b1;
            if (!c[CTL_INIT]) begin
                line_mem    = '{default: 8'h00};
                col         = 0;
                fill        = 0;
                tmr_on      = 1'b0;
                elapsed     = '0;
                strobe_wait = 1'b0;
                busy_left   = 0;
            end else if (c[CTL_STROBE]) begin
                if (idle_now) begin
                    if (d == CH_CR) begin
                        if (c[CTL_AUTOFEED]) begin
                            do_store = 1'b1;
                            ch       = CH_LF;
                        end else begin
                            col = 0;
                        end
                    end else begin
                        do_store = 1'b1;
                    end
                    if (do_store && col < STORE_DEPTH) begin
                        line_mem[col] = ch;
                        col++;
                    end
                    if (fill < FILL_MAX) begin
                        fill++;
                    end
                    strobe_wait = 1'b1;
                    tmr_on      = 1'b1;
                    elapsed     = '0;
                    st[ST_ACK]  = 1'b1;
                end
            end else if (strobe_wait) begin
                strobe_wait = 1'b0;
                busy_left   = int'(cfg_busy);
            end else if (busy_left > 0) begin
                busy_left--;
            end
        end
        lim   = (cfg_limit < STORE_DEPTH) ? cfg_limit : STORE_DEPTH;
        flush = 1'b0;
        eol   = 1'b0;
        if (fill >= lim) begin
            flush = 1'b1;
            eol   = 1'b1;
        end
        if (fill != 0 && col != 0 && col <= STORE_DEPTH && line_mem[col-1] == CH_LF) begin
            flush = 1'b1;
            eol   = 1'b1;
        end
        if (tmr_on && elapsed >= cfg_timeout) begin
            flush = 1'b1;
        end
        n = flush ? col : 0;
        if (n > STORE_DEPTH) begin
            n = STORE_DEPTH;
        end
        due_beats.push_back('{kind: 1'b0, status_byte: st, line_byte: 8'h00, last: n == 0});
        for (int i = 0; i < n; i++) begin
            due_beats.push_back('{kind: 1'b1, status_byte: 8'h00, line_byte: line_mem[i],
                                  last: i + 1 == n});
        end
        if (flush) begin
            tmr_on   = 1'b0;
            elapsed  = '0;
            line_mem = '{default: 8'h00};
            col      = 0;
            if (eol) begin
                fill = 0;
            end
        end
    endfunction

    function automatic logic [7:0] ctl_byte(input bit strobe, input bit autofeed,
                                            input bit init_n, input bit sel);
        logic [7:0] c;
        c               = 8'($urandom);
        c[CTL_STROBE]   = strobe;
        c[CTL_AUTOFEED] = autofeed;
        c[CTL_INIT]     = init_n;
        c[CTL_SELECT]   = sel;
        return c;
    endfunction

    task automatic add_tick(input logic [7:0] d, input logic [7:0] c, input bit drained);
        ticks_to_send.push_back('{data_byte: d, control_byte: c, wait_drained: drained});
        queued++;
    endtask

    task automatic add_char(input logic [7:0] d, input bit autofeed, input int gap,
                            input bit drained);
        add_tick(d, ctl_byte(1'b1, autofeed, 1'b1, 1'b1), drained);
        repeat (1 + ((gen_busy < 6) ? gen_busy : 6) + gap) begin
            add_tick(8'($urandom), ctl_byte($urandom_range(0, 9) == 0,
                                            1'($urandom_range(0, 1)), 1'b1, 1'b1), 1'b0);
        end
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_LINE_LIMIT:    cfg_limit   = val[5:0];
            REG_BUSY_TICKS:    cfg_busy    = val[7:0];
            REG_TIMEOUT_TICKS: cfg_timeout = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [5:0] limit, input logic [7:0] busy,
                              input logic [31:0] timeout);
        apb_write(REG_LINE_LIMIT, {26'd0, limit});
        apb_write(REG_BUSY_TICKS, {24'd0, busy});
        apb_write(REG_TIMEOUT_TICKS, timeout);
        gen_busy = int'(busy);
    endtask

    task automatic wait_drained();
        while (ticks_to_send.size() != 0 || tick_if.valid || due_beats.size() != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic random_phase(input int budget, input bit with_pause);
        int         start;
        int         r;
        int         gap;
        bit         pause;
        bit         paused;
        logic [7:0] d;
        start  = queued;
        paused = 1'b0;
        while (queued - start < budget) begin
            r     = $urandom_range(0, 99);
            pause = with_pause && !paused && queued - start >= budget / 2;
            if (pause) begin
                paused = 1'b1;
            end
            if (r < 8) begin
                add_tick(8'($urandom), 8'($urandom), pause);
            end else if (r < 12) begin
                add_tick(8'($urandom), ctl_byte(1'($urandom_range(0, 1)),
                                                1'($urandom_range(0, 1)), 1'b0, 1'b1), pause);
            end else if (r < 16) begin
                add_tick(8'($urandom), ctl_byte(1'($urandom_range(0, 1)),
                                                1'($urandom_range(0, 1)),
                                                1'($urandom_range(0, 1)), 1'b0), pause);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 15) begin
                    d = CH_CR;
                end else if (r < 25) begin
                    d = CH_LF;
                end else begin
                    d = 8'($urandom);
                end
                gap = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 2) : $urandom_range(3, 10);
                add_char(d, 1'($urandom_range(0, 1)), gap, pause);
            end
        end
    endtask

    always @(posedge clk) begin
        cycle_no <= cycle_no + 1;
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && ticks_taken >= 40) begin
            hold_left <= 500;
            hold_done <= 1'b1;
        end
    end

    always @(posedge clk) begin
        t_tick nxt;
        if (!rst_n) begin
            tick_if.valid <= 1'b0;
        end else if (!tick_if.valid || tick_if.ready) begin
            if (ticks_to_send.size() != 0 && (calm || $urandom_range(0, 99) >= 28) &&
                (!ticks_to_send[0].wait_drained || (!tick_if.valid && due_beats.size() == 0)))
            begin
                nxt = ticks_to_send.pop_front();
                tick_if.valid        <= 1'b1;
                tick_if.data_byte    <= nxt.data_byte;
                tick_if.control_byte <= nxt.control_byte;
            end else begin
                tick_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        t_beat got;
        t_beat want;
        if (!rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= hold_left == 0 && (calm || $urandom_range(0, 99) >= 28);
            if (tick_if.valid && tick_if.ready) begin
                printer_tick(tick_if.data_byte, tick_if.control_byte);
                ticks_taken <= ticks_taken + 1;
            end
            if (res_if.valid && res_if.ready) begin
                got = '{kind: res_if.kind, status_byte: res_if.status_byte,
                        line_byte: res_if.line_byte, last: res_if.last};
                if (due_beats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Unexpected beat: kind=%0d status=%h line=%h last=%0d",
                                 got.kind, got.status_byte, got.line_byte, got.last);
                    end
                end else begin
                    want = due_beats.pop_front();
                    if (got.kind !== want.kind || got.status_byte !== want.status_byte ||
                        got.line_byte !== want.line_byte || got.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"Mismatch: expected kind=%0d status=%h line=%h last=%0d,",
                                      " got kind=%0d status=%h line=%h last=%0d"},
                                     want.kind, want.status_byte, want.line_byte, want.last,
                                     got.kind, got.status_byte, got.line_byte, got.last);
                        end
                    end
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        tick_if.valid        = 1'b0;
        tick_if.data_byte    = 8'h00;
        tick_if.control_byte = 8'h00;
        res_if.ready         = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_config(6'd4, 8'd0, 32'd3);
        add_tick(8'h41, ctl_byte(1'b1, 1'b0, 1'b0, 1'b1), 1'b0);
        add_tick(8'h42, ctl_byte(1'b1, 1'b0, 1'b1, 1'b0), 1'b0);
        add_char(8'h00, 1'b0, 0, 1'b0);
        add_char(8'hFF, 1'b1, 0, 1'b0);
        add_char(CH_CR, 1'b0, 0, 1'b0);
        add_char(8'h78, 1'b0, 0, 1'b0);
        add_char(CH_CR, 1'b1, 0, 1'b0);
        add_char(8'h61, 1'b0, 0, 1'b0);
        add_char(8'h62, 1'b0, 0, 1'b0);
        add_char(8'h63, 1'b0, 0, 1'b0);
        add_char(8'h64, 1'b0, 0, 1'b0);
        add_char(8'h7A, 1'b0, 4, 1'b0);
        wait_drained();

        set_config(6'd32, 8'd4, 32'd1000);
        random_phase(40, 1'b0);
        wait_drained();
        set_config(6'd0, 8'd1, 32'd5);
        random_phase(30, 1'b1);
        wait_drained();
        set_config(6'd63, 8'd0, 32'hFFFF_FFFF);
        random_phase(40, 1'b0);
        wait_drained();
        set_config(6'd1, 8'd255, 32'd0);
        random_phase(15, 1'b0);
        wait_drained();
        set_config(6'd7, 8'd2, 32'd6);
        random_phase(25, 1'b0);
        wait_drained();
        set_config(6'd32, 8'd0, 32'd0);
        random_phase(20, 1'b0);
        wait_drained();

        repeat (40) @(posedge clk);
        if (mismatches == 0 && due_beats.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
